// ===== hw/rtl/echo_pulse_width_to_beep_period_core_defines.svh =====
// Assertion macros shared by the echo capture RTL.
// Each use names a label, a property and a message; clk and arst_n are taken
// from the module that uses the macro.
`ifndef ECHO_PULSE_WIDTH_TO_BEEP_PERIOD_CORE_DEFINES_SVH
`define ECHO_PULSE_WIDTH_TO_BEEP_PERIOD_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define EPW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define EPW_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define EPW_ASSERT(lbl, prop, msg)

`define EPW_NEVER(lbl, cond, msg)

`endif

`endif

// ===== hw/rtl/epw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package epw_pkg;

	// one input beat
	typedef struct packed {
		logic        overflow_event;
		logic        capture_event;
		logic [15:0] captured_count;
	} in_item_t;

	// one result beat
	typedef struct packed {
		logic [31:0] pulse_width;
		logic [12:0] beep_period;
		logic        falling_edge;
	} out_item_t;

	// capture record passed from the front end to the measurement back end
	typedef struct packed {
		logic        falling;
		logic [31:0] tally;
		logic [15:0] now;
		logic [15:0] prev;
	} meas_t;

	// register map, indexed by paddr[2]
	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_SCALE  = 1'b1;

	localparam logic [16:0] PERIOD_RST = 17'd36000;
	localparam logic [23:0] SCALE_RST  = 24'd396129;

	// distance thresholds in whole centimetres, farthest first
	localparam logic [6:0] LADDER_CM [7] = '{7'd100, 7'd80, 7'd60, 7'd40, 7'd20, 7'd10, 7'd5};
	localparam logic [12:0] LADDER_PERIOD [8] = '{13'd5000, 13'd4000, 13'd3000, 13'd2000,
		13'd1000, 13'd500, 13'd250, 13'd100};

	// first threshold reached wins; default is the last step
	function automatic logic [12:0] pick_period(input logic [31:0] dist_cm);
		logic [12:0] p;
		p = LADDER_PERIOD[7];
		for (int i = 6; i >= 0; i--) begin
			if (dist_cm >= {25'd0, LADDER_CM[i]}) begin
				p = LADDER_PERIOD[i];
			end
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/epw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module epw_front import epw_pkg::*; #(
	parameter int COUNTER_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_item,
	input  wire logic     q_full,
	output logic          push,
	output meas_t         push_data
);

	localparam int EFF_BITS = (COUNTER_BITS < 16) ? COUNTER_BITS : 16;
	localparam logic [15:0] CNT_MASK = 16'((17'd1 << EFF_BITS) - 17'd1);

	logic        echo_q;
	logic [31:0] tally_q;
	logic [15:0] prev_q;
	logic        accept;
	logic [31:0] tally_next;
	logic [15:0] now;

	assign in_ready   = !q_full;
	assign accept     = in_valid && in_ready;
	assign now        = in_item.captured_count & CNT_MASK;
	// overflow counts only while the echo is high, and before the capture
	assign tally_next = tally_q + {31'd0, in_item.overflow_event & echo_q};

	assign push              = accept && in_item.capture_event;
	assign push_data.falling = echo_q;
	assign push_data.tally   = tally_next;
	assign push_data.now     = now;
	assign push_data.prev    = prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_q  <= 1'b0;
			tally_q <= '0;
			prev_q  <= '0;
		end else if (accept) begin
			if (in_item.capture_event) begin
				echo_q  <= !echo_q;
				tally_q <= '0;
				prev_q  <= now;
			end else begin
				tally_q <= tally_next;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/epw_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "echo_pulse_width_to_beep_period_core_defines.svh"

module epw_queue import epw_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire meas_t push_data,
	output logic       full,
	output logic       rd_valid,
	output meas_t      rd_data,
	input  wire logic  pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	meas_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`EPW_NEVER(a_no_push_full, push && full, "push into full queue")
	`EPW_NEVER(a_no_pop_empty, pop && !rd_valid, "pop from empty queue")
	`EPW_NEVER(a_count_range, count_q > CNT_W'(DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

// ===== hw/rtl/epw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "echo_pulse_width_to_beep_period_core_defines.svh"

module epw_back import epw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [16:0] period,
	input  wire logic [23:0] scale,
	input  wire logic        rd_valid,
	input  wire meas_t       rd_data,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_item
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ADD  = 2'd1;
	localparam logic [1:0] ST_DIST = 2'd2;
	localparam logic [1:0] ST_CMP  = 2'd3;

	logic [1:0]  state_q;
	logic [31:0] prod_q;
	logic [15:0] now_q;
	logic [15:0] prev_q;
	logic        falling_q;
	logic [31:0] width_q;
	logic [31:0] dist_cm_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [48:0] prod_full;
	logic [55:0] dist_full;
	logic [31:0] new_width;
	logic        load_out;

	assign prod_full = {15'd0, period} * {17'd0, rd_data.tally};
	assign dist_full = {24'd0, width_q} * {32'd0, scale};
	assign new_width = prod_q + {16'd0, now_q} - {16'd0, prev_q};
	assign pop       = (state_q == ST_IDLE) && rd_valid;
	assign load_out  = (state_q == ST_CMP) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_q    <= prod_full[31:0];
			now_q     <= rd_data.now;
			prev_q    <= rd_data.prev;
			falling_q <= rd_data.falling;
		end
		if (state_q == ST_DIST) begin
			// Q32.24 product, integer centimetres only
			dist_cm_q <= dist_full[55:24];
		end
		if (load_out) begin
			out_q.pulse_width  <= width_q;
			out_q.beep_period  <= pick_period(dist_cm_q);
			out_q.falling_edge <= falling_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (rd_valid) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					// rising capture keeps the last width
					if (falling_q) begin
						width_q <= new_width;
					end
					state_q <= ST_DIST;
				end
				ST_DIST: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`EPW_ASSERT(a_pop_starts, pop |=> (state_q == ST_ADD), "pop did not start a measurement")
	`EPW_ASSERT(a_rise_from_cmp, $rose(out_valid_q) |-> ($past(state_q) == ST_CMP), "result raised outside compare step")

endmodule

`default_nettype wire

// ===== hw/rtl/echo_pulse_width_to_beep_period_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Echo pulse width capture with beep period ladder.
// in_* channel: one beat per timer event (overflow flag, capture flag, count).
// out_* channel: one beat per capture: last measured width in ticks, the beep
//   period picked from width * tick_scale, and whether the capture ended a pulse.
// Events without a capture give no result and pass the front end.
// A capture is written to the queue, popped when the back end is free, and then
//   stepped through add, distance and compare before its result shows on out_valid.
// The back end's sequencer takes a new capture only once the last one is done
//   (period multiply, width add, distance multiply, ladder compare).
// A two-beat queue sits between front and back, so in_ready only drops when
//   the queue is full; a stalled receiver holds the result register and the
//   back end waits in its compare step, then the queue fills and in_ready falls.
// Reset clears echo polarity, tally, previous capture, measured width and
//   the queue, and loads counter_period = 36000, tick_scale = 396129.
// Config (APB): reg 0 counter_period at 0x0, reg 1 tick_scale at 0x4; write
//   only while idle. pready is tied high.
module echo_pulse_width_to_beep_period_core import epw_pkg::*; #(
	parameter int COUNTER_BITS = 16,
	parameter int QUEUE_DEPTH  = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_item,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [16:0] period_q;
	logic [23:0] scale_q;
	logic        cfg_wr;

	logic  q_full;
	logic  push;
	meas_t push_data;
	logic  rd_valid;
	meas_t rd_data;
	logic  pop;

	// config registers: written on the APB access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			scale_q  <= SCALE_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_PERIOD: period_q <= pwdata[16:0];
				REG_SCALE:  scale_q  <= pwdata[23:0];
				default:    period_q <= period_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PERIOD: prdata = {15'd0, period_q};
			REG_SCALE:  prdata = {8'd0, scale_q};
			default:    prdata = '0;
		endcase
	end

	// front end: tracks echo polarity and overflow tally, queues captures
	epw_front #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	epw_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.rd_valid  (rd_valid),
		.rd_data   (rd_data),
		.pop       (pop)
	);

	// back end: width arithmetic, distance and ladder, result register
	epw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.period    (period_q),
		.scale     (scale_q),
		.rd_valid  (rd_valid),
		.rd_data   (rd_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire
